// File: hw/rtl/bsmm_pkg.sv
// bsmm_pkg: shared constants and control/status types for the blocked matrix multiplier
// used by bsmm_ctrl, bsmm_dp and blocked_square_matrix_multiply; no dependencies
`default_nettype none

package bsmm_pkg;

    // default parameter values
    localparam int MAX_N_DEF     = 8;
    localparam int ELEM_BITS_DEF = 16;

    // fixed field widths
    localparam int CFG_W        = 4;
    localparam int COORD_W      = 3;
    localparam int PRODUCT_BITS = 37;

    // size register value after reset
    localparam logic [CFG_W-1:0] SIZE_RESET = 4'd8;

    // controller to datapath commands
    typedef struct packed {
        logic               load;        // store the accepted request's pair
        logic               issue;       // read one operand pair for a mac step
        logic [COORD_W-1:0] i;
        logic [COORD_W-1:0] j;
        logic [COORD_W-1:0] k;
        logic               first;       // first term of an element
        logic               lastk;       // final term of an element
        logic               final_elem;  // final element of the matrix
    } bsmm_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [COORD_W-1:0] size_m1;     // effective size minus one
        logic               pipe_busy;   // mac pipeline still holds terms
    } bsmm_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/bsmm_ram.sv
// bsmm_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module bsmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/bsmm_ctrl.sv
// bsmm_ctrl: load/compute sequencer, walks i, j, k over the effective size
// depends on bsmm_pkg
`default_nettype none

module bsmm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              last,
    output logic                   busy,
    output bsmm_pkg::bsmm_cmd_t    cmd,
    input  wire bsmm_pkg::bsmm_stat_t stat
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    state_t                        state_reg, state_next;
    logic [bsmm_pkg::COORD_W-1:0]  i_reg, i_next;
    logic [bsmm_pkg::COORD_W-1:0]  j_reg, j_next;
    logic [bsmm_pkg::COORD_W-1:0]  k_reg, k_next;
    logic                          accept;
    logic                          k_end;
    logic                          j_end;
    logic                          i_end;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    assign k_end = (k_reg == stat.size_m1);
    assign j_end = (j_reg == stat.size_m1);
    assign i_end = (i_reg == stat.size_m1);

    // commands to the datapath
    always_comb
    begin
        cmd.load       = accept;
        cmd.issue      = (state_reg == ST_RUN);
        cmd.i          = i_reg;
        cmd.j          = j_reg;
        cmd.k          = k_reg;
        cmd.first      = (k_reg == '0);
        cmd.lastk      = k_end;
        cmd.final_elem = i_end && j_end;
    end

    // next state and loop counters
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                i_next = '0;
                j_next = '0;
                k_next = '0;
                if (accept && last)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (k_end)
                begin
                    k_next = '0;
                    if (j_end)
                    begin
                        j_next = '0;
                        if (i_end)
                        begin
                            state_next = ST_DRAIN;
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/bsmm_dp.sv
// bsmm_dp: size register, operand stores and the three-stage multiply-accumulate
// depends on bsmm_pkg and bsmm_ram
`default_nettype none

module bsmm_dp #(
    parameter int MAX_N     = bsmm_pkg::MAX_N_DEF,
    parameter int ELEM_BITS = bsmm_pkg::ELEM_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [bsmm_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic [bsmm_pkg::COORD_W-1:0]       row,
    input  wire logic [bsmm_pkg::COORD_W-1:0]       col,
    input  wire logic [ELEM_BITS-1:0]               a_value,
    input  wire logic [ELEM_BITS-1:0]               b_value,
    input  wire bsmm_pkg::bsmm_cmd_t                cmd,
    output bsmm_pkg::bsmm_stat_t                    stat,
    output logic                                    result_valid,
    output logic [bsmm_pkg::COORD_W-1:0]            out_row,
    output logic [bsmm_pkg::COORD_W-1:0]            out_col,
    output logic signed [bsmm_pkg::PRODUCT_BITS-1:0] product,
    output logic                                    out_last
);

    localparam int DEPTH = MAX_N * MAX_N;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = bsmm_pkg::COORD_W;
    localparam int PW    = bsmm_pkg::PRODUCT_BITS;
    localparam logic [bsmm_pkg::CFG_W-1:0] SIZE_MAX = bsmm_pkg::CFG_W'(MAX_N);

    logic [bsmm_pkg::CFG_W-1:0]  size_reg;
    logic [bsmm_pkg::CFG_W-1:0]  size_eff;
    logic                        in_range;
    logic                        wr_en;
    logic [AW-1:0]               waddr;
    logic [AW-1:0]               raddr_a;
    logic [AW-1:0]               raddr_b;
    logic [ELEM_BITS-1:0]        rdata_a;
    logic [ELEM_BITS-1:0]        rdata_b;
    logic signed [ELEM_BITS-1:0] op_a;
    logic signed [ELEM_BITS-1:0] op_b;
    logic signed [2*ELEM_BITS-1:0] mul_full;
    logic signed [PW-1:0]        acc_next;

    // stage 1: operands on the ram outputs
    logic                        s1_valid_reg;
    logic                        s1_first_reg;
    logic                        s1_lastk_reg;
    logic                        s1_final_reg;
    logic [CW-1:0]               s1_i_reg;
    logic [CW-1:0]               s1_j_reg;
    // stage 2: registered product
    logic                        s2_valid_reg;
    logic                        s2_first_reg;
    logic                        s2_lastk_reg;
    logic                        s2_final_reg;
    logic [CW-1:0]               s2_i_reg;
    logic [CW-1:0]               s2_j_reg;
    logic signed [PW-1:0]        prod_reg;
    // stage 3: accumulator and result
    logic signed [PW-1:0]        acc_reg;
    logic                        out_valid_reg;
    logic                        out_last_reg;
    logic [CW-1:0]               out_row_reg;
    logic [CW-1:0]               out_col_reg;
    logic signed [PW-1:0]        product_reg;

    // size register, zero acts as one and oversize clamps to MAX_N
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= bsmm_pkg::SIZE_RESET;
        end
        else if (cfg_we)
        begin
            size_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (size_reg == '0)
        begin
            size_eff = bsmm_pkg::CFG_W'(1);
        end
        else if (size_reg > SIZE_MAX)
        begin
            size_eff = SIZE_MAX;
        end
        else
        begin
            size_eff = size_reg;
        end
    end

    assign stat.size_m1   = CW'(size_eff - 1'b1);
    assign stat.pipe_busy = s1_valid_reg || s2_valid_reg;

    // store addresses: row-major, MAX_N entries per row
    assign in_range = (bsmm_pkg::CFG_W'(row) < size_eff) && (bsmm_pkg::CFG_W'(col) < size_eff);
    assign wr_en    = cmd.load && in_range;
    assign waddr    = AW'(row * MAX_N + col);
    assign raddr_a  = AW'(cmd.i * MAX_N + cmd.k);
    assign raddr_b  = AW'(cmd.k * MAX_N + cmd.j);

    bsmm_ram #(
        .WIDTH (ELEM_BITS),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store_a (
        .clk   (clk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (a_value),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    bsmm_ram #(
        .WIDTH (ELEM_BITS),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store_b (
        .clk   (clk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (b_value),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    // signed multiply, wrapped or extended to the product width
    assign op_a     = rdata_a;
    assign op_b     = rdata_b;
    assign mul_full = op_a * op_b;

    // accumulate, restarting on the first term of each element
    assign acc_next = (s2_first_reg ? PW'(0) : acc_reg) + prod_reg;

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= cmd.issue;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg && s2_lastk_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        s1_first_reg <= cmd.first;
        s1_lastk_reg <= cmd.lastk;
        s1_final_reg <= cmd.final_elem;
        s1_i_reg     <= cmd.i;
        s1_j_reg     <= cmd.j;

        s2_first_reg <= s1_first_reg;
        s2_lastk_reg <= s1_lastk_reg;
        s2_final_reg <= s1_final_reg;
        s2_i_reg     <= s1_i_reg;
        s2_j_reg     <= s1_j_reg;
        prod_reg     <= PW'(mul_full);

        if (s2_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        if (s2_valid_reg && s2_lastk_reg)
        begin
            product_reg  <= acc_next;
            out_row_reg  <= s2_i_reg;
            out_col_reg  <= s2_j_reg;
            out_last_reg <= s2_final_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign product      = product_reg;
    assign out_last     = out_valid_reg && out_last_reg;

endmodule

`default_nettype wire

// File: hw/rtl/blocked_square_matrix_multiply.sv
// blocked_square_matrix_multiply: loads A and B one pair per cycle while not busy, then emits C = A x B
// loading requests leave the block ready; after the request marked last, it emits the results for
// n = effective size in row-major order, each element summed from n multiply-accumulate terms
// busy stays high until the final result is shown; the rate is set by the single shared multiply-accumulate
// reset: asynchronous active-low, size register returns to 8, operand stores are not cleared
// the receiver cannot stall: each result is shown for exactly one cycle with result_valid
// depends on bsmm_pkg, bsmm_ctrl, bsmm_dp, bsmm_ram
`default_nettype none

module blocked_square_matrix_multiply #(
    parameter int MAX_N     = bsmm_pkg::MAX_N_DEF,
    parameter int ELEM_BITS = bsmm_pkg::ELEM_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [bsmm_pkg::CFG_W-1:0]          cfg_data,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [bsmm_pkg::COORD_W-1:0]        row,
    input  wire logic [bsmm_pkg::COORD_W-1:0]        col,
    input  wire logic [ELEM_BITS-1:0]                a_value,
    input  wire logic [ELEM_BITS-1:0]                b_value,
    input  wire logic                                last,
    output logic                                     result_valid,
    output logic [bsmm_pkg::COORD_W-1:0]             out_row,
    output logic [bsmm_pkg::COORD_W-1:0]             out_col,
    output logic signed [bsmm_pkg::PRODUCT_BITS-1:0] product,
    output logic                                     out_last
);

    bsmm_pkg::bsmm_cmd_t  cmd;
    bsmm_pkg::bsmm_stat_t stat;

    // sequencer
    bsmm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .last  (last),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    // stores and mac pipeline
    bsmm_dp #(
        .MAX_N     (MAX_N),
        .ELEM_BITS (ELEM_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .row          (row),
        .col          (col),
        .a_value      (a_value),
        .b_value      (b_value),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .out_row      (out_row),
        .out_col      (out_col),
        .product      (product),
        .out_last     (out_last)
    );

    // results only appear while a multiply is in progress
    assert property (@(posedge clk) disable iff (!rst_n) result_valid |-> busy)
        else $error("result strobe while idle");

    // a request marked last starts the multiply
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy && last) |=> busy)
        else $error("multiply did not start after last request");

    // a plain loading request leaves the block ready
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy && !last) |=> !busy)
        else $error("loading request made the block busy");

    // the final element ends the result stream
    assert property (@(posedge clk) disable iff (!rst_n) out_last |=> !result_valid)
        else $error("result after final element");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// tb_top: self-checking bench for blocked_square_matrix_multiply (C = A x B in exact fixed point)
// keeps its own copy of both operand stores and the size register and predicts every C element
// depends on bsmm_pkg and blocked_square_matrix_multiply
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_N        = bsmm_pkg::MAX_N_DEF;
    localparam int ELEM_BITS    = bsmm_pkg::ELEM_BITS_DEF;
    localparam int DIM_SQ       = MAX_N * MAX_N;
    localparam int COORD_W      = bsmm_pkg::COORD_W;
    localparam int CFG_W        = bsmm_pkg::CFG_W;
    localparam int PRODUCT_BITS = bsmm_pkg::PRODUCT_BITS;

    // value mixes for operand content
    localparam int VALS_RANDOM  = 0;
    localparam int VALS_EXTREME = 1;
    localparam int VALS_SMALL   = 2;

    localparam int RANDOM_ITEMS = 100;

    // one expected element of C
    typedef struct {
        logic [COORD_W-1:0]             r;
        logic [COORD_W-1:0]             c;
        logic signed [PRODUCT_BITS-1:0] prod;
        logic                           lst;
    } c_elem_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [CFG_W-1:0]               cfg_data;
    logic                           start;
    logic                           busy;
    logic [COORD_W-1:0]             row;
    logic [COORD_W-1:0]             col;
    logic [ELEM_BITS-1:0]           a_value;
    logic [ELEM_BITS-1:0]           b_value;
    logic                           last;
    logic                           result_valid;
    logic [COORD_W-1:0]             out_row;
    logic [COORD_W-1:0]             out_col;
    logic signed [PRODUCT_BITS-1:0] product;
    logic                           out_last;

    // predictor state
    logic signed [ELEM_BITS-1:0] mat_a [DIM_SQ];
    logic signed [ELEM_BITS-1:0] mat_b [DIM_SQ];
    logic [CFG_W-1:0]            size_reg;
    c_elem_t                     expected_c[$];

    int errors;
    int pairs_loaded;

    blocked_square_matrix_multiply #(
        .MAX_N     (MAX_N),
        .ELEM_BITS (ELEM_BITS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .row          (row),
        .col          (col),
        .a_value      (a_value),
        .b_value      (b_value),
        .last         (last),
        .result_valid (result_valid),
        .out_row      (out_row),
        .out_col      (out_col),
        .product      (product),
        .out_last     (out_last)
    );

    // clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // mismatch reporting, log kept short on a badly broken block
    task automatic report(input string msg);
        if (errors < 40)
            $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    // size register as the block uses it
    function automatic int eff_size();
        if (size_reg == 0)
            return 1;
        if (size_reg > MAX_N)
            return MAX_N;
        return int'(size_reg);
    endfunction

    // update the stores and, on last, queue every element of C in row-major order
    task automatic predict_request(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c,
                                   input logic [ELEM_BITS-1:0] a, input logic [ELEM_BITS-1:0] b,
                                   input logic lst);
        int n;
        c_elem_t e;
        logic signed [PRODUCT_BITS-1:0] acc;
        n = eff_size();
        if (r < n && c < n)
        begin
            mat_a[r * MAX_N + c] = a;
            mat_b[r * MAX_N + c] = b;
        end
        if (lst)
        begin
            for (int i = 0; i < n; i++)
            begin
                for (int j = 0; j < n; j++)
                begin
                    acc = '0;
                    for (int k = 0; k < n; k++)
                        acc = acc + mat_a[i * MAX_N + k] * mat_b[k * MAX_N + j];
                    e.r    = i[COORD_W-1:0];
                    e.c    = j[COORD_W-1:0];
                    e.prod = acc;
                    e.lst  = (i == n - 1 && j == n - 1);
                    expected_c.push_back(e);
                end
            end
        end
    endtask

    // sender gap: mostly none or short, now and then long
    function automatic int pick_gap(input bit nogap);
        int p;
        if (nogap)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ELEM_BITS-1:0] pick_value(input int mix);
        if (mix == VALS_EXTREME)
        begin
            case ($urandom_range(0, 6))
                0: return 16'h8000;
                1: return 16'h7fff;
                2: return 16'h0000;
                3: return 16'hffff;
                4: return 16'h0001;
                5: return 16'h0100;
                default: return 16'hff00;
            endcase
        end
        if (mix == VALS_RANDOM)
            return ELEM_BITS'($urandom());
        return ELEM_BITS'($urandom_range(0, 511)) - ELEM_BITS'(256);
    endfunction

    // one request: hold it until the block takes it, then predict and idle
    task automatic send_request(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c,
                                input logic [ELEM_BITS-1:0] a, input logic [ELEM_BITS-1:0] b,
                                input logic lst, input int gap);
        @(negedge clk);
        start   <= 1'b1;
        row     <= r;
        col     <= c;
        a_value <= a;
        b_value <= b;
        last    <= lst;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (r < eff_size() && c < eff_size())
            pairs_loaded++;
        predict_request(r, c, a, b, lst);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // request at a position outside the current size, ignored by the stores
    task automatic send_outside(input int n, input logic lst, input int gap);
        int r;
        int c;
        if ($urandom_range(0, 1) == 1)
        begin
            r = $urandom_range(n, MAX_N - 1);
            c = $urandom_range(0, MAX_N - 1);
        end
        else
        begin
            r = $urandom_range(0, MAX_N - 1);
            c = $urandom_range(n, MAX_N - 1);
        end
        send_request(COORD_W'(r), COORD_W'(c), ELEM_BITS'($urandom()), ELEM_BITS'($urandom()),
                     lst, gap);
    endtask

    // stop sending and let the block drain every expected element
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (expected_c.size() != 0)
            @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    task automatic write_size(input logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        size_reg = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // load cnt distinct positions of an n x n matrix in random order, with optional noise
    task automatic load_matrix(input int n, input int cnt, input int mix, input bit fin,
                               input bit last_outside, input bit nogap);
        int pos [DIM_SQ];
        int s;
        int t;
        for (int idx = 0; idx < n * n; idx++)
            pos[idx] = idx;
        for (int idx = n * n - 1; idx > 0; idx--)
        begin
            s        = $urandom_range(0, idx);
            t        = pos[idx];
            pos[idx] = pos[s];
            pos[s]   = t;
        end
        for (int idx = 0; idx < cnt; idx++)
        begin
            if (n < MAX_N && $urandom_range(0, 9) == 0)
                send_outside(n, 1'b0, pick_gap(nogap));
            send_request(COORD_W'(pos[idx] / n), COORD_W'(pos[idx] % n),
                         pick_value(mix), pick_value(mix),
                         fin && !last_outside && idx == cnt - 1, pick_gap(nogap));
        end
        if (fin && last_outside)
            send_outside(n, 1'b1, pick_gap(nogap));
    endtask

    // result checking against the oldest expected element
    always @(posedge clk)
    begin : check_c
        c_elem_t want;
        if (rst_n === 1'b1 && result_valid === 1'b1)
        begin
            if (expected_c.size() == 0)
                report($sformatf("element (%0d,%0d) with none expected", out_row, out_col));
            else
            begin
                want = expected_c.pop_front();
                if (out_row !== want.r)
                    report($sformatf("out_row %0d, expected %0d", out_row, want.r));
                if (out_col !== want.c)
                    report($sformatf("out_col %0d, expected %0d", out_col, want.c));
                if (product !== want.prod)
                    report($sformatf("product at (%0d,%0d) is %0d, expected %0d",
                                     want.r, want.c, product, want.prod));
                if (out_last !== want.lst)
                    report($sformatf("out_last at (%0d,%0d) is %0b, expected %0b",
                                     want.r, want.c, out_last, want.lst));
            end
        end
    end

    // reset size of 8: full load, which also writes every store entry once
    task automatic test_reset_size();
        load_matrix(MAX_N, DIM_SQ, VALS_EXTREME, 1'b1, 1'b0, 1'b0);
        wait_idle();
    endtask

    // 1 x 1 matrices, size register zero acts as one, last outside the size
    task automatic test_single_element();
        write_size(4'd1);
        send_request(3'd0, 3'd0, 16'h8000, 16'h8000, 1'b1, 0);
        wait_idle();
        write_size(4'd0);
        send_request(3'd0, 3'd0, 16'h7fff, 16'h8000, 1'b1, 0);
        wait_idle();
        send_request(3'd1, 3'd0, 16'h1234, 16'hfedc, 1'b1, 0);
        wait_idle();
    endtask

    // 2 x 2 load with ignored positions in between
    task automatic test_ignored_positions();
        write_size(4'd2);
        send_request(3'd0, 3'd0, 16'h7fff, 16'h7fff, 1'b0, 0);
        send_request(3'd7, 3'd7, 16'h5555, 16'haaaa, 1'b0, 1);
        send_request(3'd0, 3'd1, 16'hffff, 16'h0001, 1'b0, 0);
        send_request(3'd2, 3'd1, 16'haaaa, 16'h5555, 1'b0, 0);
        send_request(3'd1, 3'd0, 16'h0000, 16'h8000, 1'b0, 2);
        send_request(3'd1, 3'd2, 16'h0f0f, 16'hf0f0, 1'b0, 0);
        send_request(3'd1, 3'd1, 16'h8000, 16'h7fff, 1'b1, 0);
        wait_idle();
        send_request(3'd7, 3'd7, 16'hffff, 16'hffff, 1'b1, 0);
        wait_idle();
    endtask

    // size register above the maximum acts as 8, then the maximum itself
    task automatic test_size_above_max();
        write_size(4'd15);
        send_request(3'd7, 3'd7, 16'h7fff, 16'h8000, 1'b1, 0);
        wait_idle();
        write_size(4'd8);
        send_request(3'd0, 3'd7, 16'h8000, 16'h8000, 1'b0, 0);
        send_request(3'd7, 3'd0, 16'h8000, 16'h8000, 1'b1, 0);
        wait_idle();
    endtask

    // random sizes and loads: full, partial, abandoned, last outside the size
    task automatic test_random_loads();
        int goal;
        int n;
        int kind;
        int p;
        bit nogap;
        goal = pairs_loaded + RANDOM_ITEMS;
        while (pairs_loaded < goal)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                wait_idle();
                p = $urandom_range(0, 19);
                if (p == 0)
                    write_size(4'd0);
                else if (p == 1)
                    write_size(CFG_W'($urandom_range(MAX_N + 1, 15)));
                else
                    write_size(CFG_W'($urandom_range(1, MAX_N)));
            end
            n     = eff_size();
            kind  = $urandom_range(0, 9);
            nogap = ($urandom_range(0, 3) == 0);
            if (kind <= 3)
                load_matrix(n, n * n, $urandom_range(0, 2), 1'b1, 1'b0, nogap);
            else if (kind == 8)
                load_matrix(n, $urandom_range(1, n * n), $urandom_range(0, 2), 1'b0, 1'b0,
                            nogap);
            else if (kind == 9 && n < MAX_N)
                load_matrix(n, $urandom_range(0, n * n), $urandom_range(0, 2), 1'b1, 1'b1,
                            nogap);
            else
                load_matrix(n, $urandom_range(1, n * n), $urandom_range(0, 2), 1'b1, 1'b0,
                            nogap);
        end
    endtask

    // stimulus sequence
    initial
    begin
        errors       = 0;
        pairs_loaded = 0;
        size_reg     = bsmm_pkg::SIZE_RESET;
        for (int idx = 0; idx < DIM_SQ; idx++)
        begin
            mat_a[idx] = '0;
            mat_b[idx] = '0;
        end
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        start    = 1'b0;
        row      = '0;
        col      = '0;
        a_value  = '0;
        b_value  = '0;
        last     = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_size();
        test_single_element();
        test_ignored_positions();
        test_size_above_max();
        test_random_loads();

        wait_idle();
        repeat (16) @(posedge clk);
        if (errors == 0)
            $display("** blocked_square_matrix_multiply: PASSED **");
        else
            $display("** blocked_square_matrix_multiply: FAILED **");
        $finish;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("** blocked_square_matrix_multiply: FAILED **");
        $finish;
    end

endmodule
